// ----- rtl/core/sps_pkg.sv -----
// Shared types, parse-step codes, error codes and the step length table
// for the SPS timing rewriter. No dependencies.
package sps_pkg;

    localparam int MAX_SCAN_BYTES = 4096;
    localparam int BCNT_W         = $clog2(MAX_SCAN_BYTES + 1);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_TS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_TS  = 3'd4;

    // parse steps: start code bytes, NAL header, then SPS / VUI syntax elements
    localparam logic [5:0] ST_SC0         = 6'd0;
    localparam logic [5:0] ST_SC3         = 6'd3;
    localparam logic [5:0] ST_HDR         = 6'd4;
    localparam logic [5:0] ST_PROFILE     = 6'd5;
    localparam logic [5:0] ST_SPS_ID      = 6'd6;
    localparam logic [5:0] ST_LOG2_FN     = 6'd7;
    localparam logic [5:0] ST_POC_TYPE    = 6'd8;
    localparam logic [5:0] ST_LOG2_POC    = 6'd9;
    localparam logic [5:0] ST_DELTA_ZERO  = 6'd10;
    localparam logic [5:0] ST_OFS_NONREF  = 6'd11;
    localparam logic [5:0] ST_OFS_TB      = 6'd12;
    localparam logic [5:0] ST_NUM_CYCLE   = 6'd13;
    localparam logic [5:0] ST_OFS_REF     = 6'd14;
    localparam logic [5:0] ST_MAX_REFS    = 6'd15;
    localparam logic [5:0] ST_GAPS        = 6'd16;
    localparam logic [5:0] ST_WIDTH       = 6'd17;
    localparam logic [5:0] ST_HEIGHT      = 6'd18;
    localparam logic [5:0] ST_FRAME_ONLY  = 6'd19;
    localparam logic [5:0] ST_MBAFF       = 6'd20;
    localparam logic [5:0] ST_DIRECT8     = 6'd21;
    localparam logic [5:0] ST_CROP_FLAG   = 6'd22;
    localparam logic [5:0] ST_CROP_OFS    = 6'd23;
    localparam logic [5:0] ST_VUI_FLAG    = 6'd24;
    localparam logic [5:0] ST_AR_FLAG     = 6'd25;
    localparam logic [5:0] ST_AR_IDC      = 6'd26;
    localparam logic [5:0] ST_SAR         = 6'd27;
    localparam logic [5:0] ST_OVS_FLAG    = 6'd28;
    localparam logic [5:0] ST_OVS_APPR    = 6'd29;
    localparam logic [5:0] ST_VST_FLAG    = 6'd30;
    localparam logic [5:0] ST_VFMT        = 6'd31;
    localparam logic [5:0] ST_COL_FLAG    = 6'd32;
    localparam logic [5:0] ST_COL_DESC    = 6'd33;
    localparam logic [5:0] ST_CLOC_FLAG   = 6'd34;
    localparam logic [5:0] ST_CLOC        = 6'd35;
    localparam logic [5:0] ST_TIME_FLAG   = 6'd36;
    localparam logic [5:0] ST_TICK        = 6'd37;
    localparam logic [5:0] ST_TSCALE      = 6'd38;
    localparam logic [5:0] ST_AFTER       = 6'd39;
    localparam logic [5:0] ST_IDLE        = 6'd63;

    localparam logic [7:0] AR_EXTENDED    = 8'd255;
    localparam logic [4:0] NAL_SPS        = 5'd7;
    localparam logic [7:0] EPB_BYTE       = 8'h03;

    localparam logic [3:0] E_NONE      = 4'd0;
    localparam logic [3:0] E_START     = 4'd1;
    localparam logic [3:0] E_NOT_SPS   = 4'd2;
    localparam logic [3:0] E_WIDTH     = 4'd3;
    localparam logic [3:0] E_HEIGHT    = 4'd4;
    localparam logic [3:0] E_NO_VUI    = 4'd5;
    localparam logic [3:0] E_NO_TIMING = 4'd6;
    localparam logic [3:0] E_TICK      = 4'd7;
    localparam logic [3:0] E_OLD_SCALE = 4'd8;
    localparam logic [3:0] E_ZERO_AFT  = 4'd9;
    localparam logic [3:0] E_GOLOMB    = 4'd10;
    localparam logic [3:0] E_SCAN      = 4'd11;
    localparam logic [3:0] E_EARLY     = 4'd12;

    typedef struct packed {
        logic [15:0] width_mbs_m1;
        logic [15:0] height_max_m1;
        logic [31:0] units_in_tick;
        logic [31:0] old_ts;
        logic [31:0] new_ts;
    } t_cfg;

    typedef struct packed {
        logic [5:0]  step;
        logic [5:0]  bits_left;
        logic [31:0] accum;
        logic [5:0]  gz;
        logic [31:0] loop_rem;
        logic [3:0]  err;
        logic        done;
    } t_pstate;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic [3:0] err;
    } t_result;

    // bit length of fixed-width steps; zero marks an Exp-Golomb element
    function automatic logic [5:0] f_step_len(input logic [5:0] step);
        logic [5:0] len;
        len = 6'd0;
        case (step)
            ST_PROFILE, ST_SAR:                        len = 6'd24;
            ST_DELTA_ZERO, ST_GAPS, ST_FRAME_ONLY,
            ST_MBAFF, ST_DIRECT8, ST_CROP_FLAG,
            ST_VUI_FLAG, ST_AR_FLAG, ST_OVS_FLAG,
            ST_OVS_APPR, ST_VST_FLAG, ST_COL_FLAG,
            ST_CLOC_FLAG, ST_TIME_FLAG:                len = 6'd1;
            ST_AR_IDC:                                 len = 6'd8;
            ST_VFMT:                                   len = 6'd4;
            ST_COL_DESC:                               len = 6'd24;
            ST_TICK, ST_TSCALE:                        len = 6'd32;
            ST_AFTER:                                  len = 6'd16;
            default:                                   len = 6'd0;
        endcase
        if (step == ST_SAR) len = 6'd32;
        return len;
    endfunction

    // first error wins; parsing stops
    function automatic t_pstate f_fail(input t_pstate s, input logic [3:0] code);
        t_pstate r;
        r = s;
        if (s.err == E_NONE) r.err = code;
        r.step = ST_IDLE;
        return r;
    endfunction

endpackage

// ----- rtl/core/sps_stream_if.sv -----
// Valid/ready channel interfaces for stream bytes in and rewritten bytes out.
// Depends on nothing.
interface sps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       patch_done;
    logic [3:0] error_code;
    modport source (output valid, output out_byte, output out_last, output patch_done,
                    output error_code, input ready);
    modport sink   (input valid, input out_byte, input out_last, input patch_done,
                    input error_code, output ready);
endinterface

// ----- rtl/core/sps_timing_rewriter.sv -----
// Top level of the SPS timing rewriter: configuration registers, parser and
// result register. Depends on sps_pkg, sps_stream_if, sps_parser.
//
// Usage:
//   i_in carries an H.264 elementary stream, one byte per item, with in_last on
//   the final byte. o_out returns every byte, in order, one result item per input
//   item: the bits of the timescale field in the SPS VUI timing info are replaced
//   by the configured new value, patch_done rises once the rewrite and the
//   following 16-bit check succeed, and error_code holds the first error found
//   (sticky until reset).
//   o_out.valid rises in the cycle after acceptance. Throughput is one item per cycle
//   when the receiver does not stall: the eight bit steps of a byte are chained
//   combinationally in the parser between the parse state and the result register.
//   When the receiver stalls, the result register holds its item and i_in.ready
//   drops; ready returns in the cycle the held item is taken, so a new item can be
//   accepted in the same cycle the old one leaves.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) is written while no item is
//   in flight; unknown indexes are dropped.
//   Synchronous active-low reset clears the parse state, the byte counter and the
//   result valid flag, and loads the default configuration. Nothing restarts
//   parsing after success or error except reset.
module sps_timing_rewriter
    import sps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sps_in_if.sink                i_in,
    sps_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic              w_accept;
    t_result           w_result;
    t_pstate           w_state;
    logic [BCNT_W-1:0] w_byte_count;

    // accept when the result slot is empty or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mbs_m1  <= 16'd79;
            r_cfg.height_max_m1 <= 16'd44;
            r_cfg.units_in_tick <= 32'd1;
            r_cfg.old_ts        <= 32'd50;
            r_cfg.new_ts        <= 32'd48;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_cfg.width_mbs_m1  <= i_cfg_data[15:0];
                CFG_HEIGHT: r_cfg.height_max_m1 <= i_cfg_data[15:0];
                CFG_TICK:   r_cfg.units_in_tick <= i_cfg_data;
                CFG_OLD_TS: r_cfg.old_ts        <= i_cfg_data;
                CFG_NEW_TS: r_cfg.new_ts        <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    sps_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_byte       (i_in.in_byte),
        .i_last       (i_in.in_last),
        .o_result     (w_result),
        .o_state      (w_state),
        .o_byte_count (w_byte_count)
    );

    // hold the result until taken; load a new one on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_out <= w_result;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out.data;
    assign o_out.out_last   = r_out.last;
    assign o_out.patch_done = r_out.done;
    assign o_out.error_code = r_out.err;

    // a set error code never changes
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state.err != E_NONE) |=> $stable(w_state.err))
        else $error("error code changed after being set");

    // success and error are exclusive
    a_done_xor_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_state.done && w_state.err != E_NONE))
        else $error("patch_done together with an error");

    // a finished parse has stopped
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state.done || w_state.err != E_NONE) |-> (w_state.step == ST_IDLE))
        else $error("parser still active after done or error");

    // the byte counter saturates at the scan limit
    a_bcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_byte_count <= BCNT_W'(MAX_SCAN_BYTES))
        else $error("byte counter past scan limit");

endmodule

// ----- rtl/core/sps_bit_unit.sv -----
// One bit of SPS parsing: Exp-Golomb or fixed-width field step and the
// transition to the next syntax element. Depends on sps_pkg.
module sps_bit_unit
    import sps_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_pstate i_state,
    input  logic    i_bit,
    input  logic    i_en,
    output t_pstate o_state,
    output logic    o_bit
);

    function automatic t_pstate f_go(input t_pstate s, input logic [5:0] step);
        t_pstate r;
        r = s;
        r.step      = step;
        r.bits_left = f_step_len(step);
        r.accum     = '0;
        r.gz        = '0;
        return r;
    endfunction

    function automatic t_pstate f_finish(input t_pstate s, input logic [31:0] v,
                                         input t_cfg c);
        t_pstate r;
        logic    nz;
        logic [31:0] lr;
        r  = s;
        nz = (v != 32'd0);
        lr = s.loop_rem - 32'd1;
        case (s.step)
            ST_PROFILE:    r = f_go(s, ST_SPS_ID);
            ST_SPS_ID:     r = f_go(s, ST_LOG2_FN);
            ST_LOG2_FN:    r = f_go(s, ST_POC_TYPE);
            ST_POC_TYPE:   r = f_go(s, !nz ? ST_LOG2_POC :
                                       (v == 32'd1 ? ST_DELTA_ZERO : ST_MAX_REFS));
            ST_LOG2_POC:   r = f_go(s, ST_MAX_REFS);
            ST_DELTA_ZERO: r = f_go(s, ST_OFS_NONREF);
            ST_OFS_NONREF: r = f_go(s, ST_OFS_TB);
            ST_OFS_TB:     r = f_go(s, ST_NUM_CYCLE);
            ST_NUM_CYCLE: begin
                r = f_go(s, nz ? ST_OFS_REF : ST_MAX_REFS);
                r.loop_rem = v;
            end
            ST_OFS_REF: begin
                r = f_go(s, (lr == 32'd0) ? ST_MAX_REFS : ST_OFS_REF);
                r.loop_rem = lr;
            end
            ST_MAX_REFS:   r = f_go(s, ST_GAPS);
            ST_GAPS:       r = f_go(s, ST_WIDTH);
            ST_WIDTH:      r = (v != {16'd0, c.width_mbs_m1}) ? f_fail(s, E_WIDTH)
                                                                : f_go(s, ST_HEIGHT);
            ST_HEIGHT:     r = (v > {16'd0, c.height_max_m1}) ? f_fail(s, E_HEIGHT)
                                                               : f_go(s, ST_FRAME_ONLY);
            ST_FRAME_ONLY: r = f_go(s, nz ? ST_DIRECT8 : ST_MBAFF);
            ST_MBAFF:      r = f_go(s, ST_DIRECT8);
            ST_DIRECT8:    r = f_go(s, ST_CROP_FLAG);
            ST_CROP_FLAG: begin
                r = f_go(s, nz ? ST_CROP_OFS : ST_VUI_FLAG);
                if (nz) r.loop_rem = 32'd4;
            end
            ST_CROP_OFS: begin
                r = f_go(s, (lr == 32'd0) ? ST_VUI_FLAG : ST_CROP_OFS);
                r.loop_rem = lr;
            end
            ST_VUI_FLAG:   r = nz ? f_go(s, ST_AR_FLAG) : f_fail(s, E_NO_VUI);
            ST_AR_FLAG:    r = f_go(s, nz ? ST_AR_IDC : ST_OVS_FLAG);
            ST_AR_IDC:     r = f_go(s, (v == {24'd0, AR_EXTENDED}) ? ST_SAR : ST_OVS_FLAG);
            ST_SAR:        r = f_go(s, ST_OVS_FLAG);
            ST_OVS_FLAG:   r = f_go(s, nz ? ST_OVS_APPR : ST_VST_FLAG);
            ST_OVS_APPR:   r = f_go(s, ST_VST_FLAG);
            ST_VST_FLAG:   r = f_go(s, nz ? ST_VFMT : ST_CLOC_FLAG);
            ST_VFMT:       r = f_go(s, ST_COL_FLAG);
            ST_COL_FLAG:   r = f_go(s, nz ? ST_COL_DESC : ST_CLOC_FLAG);
            ST_COL_DESC:   r = f_go(s, ST_CLOC_FLAG);
            ST_CLOC_FLAG: begin
                r = f_go(s, nz ? ST_CLOC : ST_TIME_FLAG);
                if (nz) r.loop_rem = 32'd2;
            end
            ST_CLOC: begin
                r = f_go(s, (lr == 32'd0) ? ST_TIME_FLAG : ST_CLOC);
                r.loop_rem = lr;
            end
            ST_TIME_FLAG:  r = nz ? f_go(s, ST_TICK) : f_fail(s, E_NO_TIMING);
            ST_TICK:       r = (v != c.units_in_tick) ? f_fail(s, E_TICK)
                                                      : f_go(s, ST_TSCALE);
            ST_TSCALE:     r = (v != c.old_ts) ? f_fail(s, E_OLD_SCALE)
                                               : f_go(s, ST_AFTER);
            ST_AFTER: begin
                if (!nz) begin
                    r = f_fail(s, E_ZERO_AFT);
                end else begin
                    r.done = 1'b1;
                    r.step = ST_IDLE;
                end
            end
            default:       r.step = ST_IDLE;
        endcase
        return r;
    endfunction

    t_pstate     w_s;
    logic [5:0]  w_len;
    logic [5:0]  w_bl_dec;
    logic [31:0] w_acc;
    logic [31:0] w_gval;

    assign w_len    = f_step_len(i_state.step);
    assign w_bl_dec = i_state.bits_left - 6'd1;
    assign w_acc    = {i_state.accum[30:0], i_bit};
    assign w_gval   = ((32'd1 << i_state.gz[4:0]) - 32'd1) + w_acc;

    always_comb begin
        w_s   = i_state;
        o_bit = i_bit;
        if (i_en && i_state.step != ST_IDLE) begin
            if (w_len == 6'd0) begin
                if (i_state.bits_left == 6'd0) begin
                    if (!i_bit) begin
                        w_s.gz = i_state.gz + 6'd1;
                        if (w_s.gz >= 6'd32) w_s = f_fail(w_s, E_GOLOMB);
                    end else if (i_state.gz == 6'd0) begin
                        w_s = f_finish(i_state, 32'd0, i_cfg);
                    end else begin
                        w_s.bits_left = i_state.gz;
                        w_s.accum     = '0;
                    end
                end else begin
                    w_s.accum     = w_acc;
                    w_s.bits_left = w_bl_dec;
                    if (w_bl_dec == 6'd0) w_s = f_finish(w_s, w_gval, i_cfg);
                end
            end else if (i_state.bits_left == 6'd0 || i_state.bits_left > 6'd32) begin
                w_s.step = ST_IDLE;
            end else begin
                if (i_state.step == ST_TSCALE) o_bit = i_cfg.new_ts[w_bl_dec[4:0]];
                w_s.accum     = w_acc;
                w_s.bits_left = w_bl_dec;
                if (w_bl_dec == 6'd0) w_s = f_finish(w_s, w_acc, i_cfg);
            end
        end
    end

    assign o_state = w_s;

endmodule

// ----- rtl/core/sps_parser.sv -----
// Byte-level SPS parser: start code and NAL header checks, emulation-prevention
// skip, eight chained bit units, scan limit and parse state registers.
// Depends on sps_pkg and sps_bit_unit.
module sps_parser
    import sps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_result,
    output t_pstate    o_state,
    output logic [BCNT_W-1:0] o_byte_count
);

    t_pstate            r_state, n_state;
    logic [1:0]         r_zero_run, n_zero_run;
    logic [BCNT_W-1:0]  r_byte_count, n_byte_count;

    t_pstate    w_pre;
    logic       w_run;
    t_pstate    w_chain [0:8];
    logic [7:0] w_nb;
    logic [7:0] w_out;

    localparam logic [BCNT_W-1:0] SCAN_MAX = BCNT_W'(MAX_SCAN_BYTES);

    always_comb begin
        w_pre = r_state;
        w_run = 1'b0;
        if (r_state.step != ST_IDLE) begin
            if (r_byte_count >= SCAN_MAX) begin
                w_pre = f_fail(r_state, E_SCAN);
            end else if (r_state.step < ST_HDR) begin
                if (i_byte != ((r_state.step == ST_SC3) ? 8'd1 : 8'd0))
                    w_pre = f_fail(r_state, E_START);
                else
                    w_pre.step = r_state.step + 6'd1;
            end else if (r_state.step == ST_HDR) begin
                if (i_byte[4:0] == NAL_SPS) begin
                    w_pre.step      = ST_PROFILE;
                    w_pre.bits_left = f_step_len(ST_PROFILE);
                    w_pre.accum     = '0;
                    w_pre.gz        = '0;
                end else begin
                    w_pre = f_fail(r_state, E_NOT_SPS);
                end
            end else begin
                // skip emulation-prevention bytes
                w_run = !(r_zero_run == 2'd2 && i_byte == EPB_BYTE);
            end
        end
    end

    assign w_chain[0] = w_pre;

    for (genvar g = 0; g < 8; g++) begin : g_bit
        sps_bit_unit u_bit (
            .i_cfg   (i_cfg),
            .i_state (w_chain[g]),
            .i_bit   (i_byte[7-g]),
            .i_en    (w_run),
            .o_state (w_chain[g+1]),
            .o_bit   (w_nb[7-g])
        );
    end

    always_comb begin
        n_state = w_run ? w_chain[8] : w_pre;
        w_out   = w_run ? w_nb : i_byte;
        n_byte_count = (r_byte_count < SCAN_MAX) ? r_byte_count + 1'b1 : r_byte_count;
        if (w_out == 8'd0)
            n_zero_run = (r_zero_run < 2'd2) ? r_zero_run + 2'd1 : r_zero_run;
        else
            n_zero_run = 2'd0;
        if (i_last && n_state.step != ST_IDLE) n_state = f_fail(n_state, E_EARLY);
    end

    assign o_result.data = w_out;
    assign o_result.last = i_last;
    assign o_result.done = n_state.done;
    assign o_result.err  = n_state.err;
    assign o_state       = r_state;
    assign o_byte_count  = r_byte_count;

    // all-zero state starts at the first start-code byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_zero_run   <= '0;
            r_byte_count <= '0;
        end else if (i_accept) begin
            r_state      <= n_state;
            r_zero_run   <= n_zero_run;
            r_byte_count <= n_byte_count;
        end
    end

endmodule
